/* hdl/rrm_pkg.sv */
`default_nettype none

package rrm_pkg;

  // Command codes carried in the input tuser field.
  typedef enum logic [1:0] {
    CMD_PLAY = 2'd0,
    CMD_TICK = 2'd1,
    CMD_STOP = 2'd2
  } cmd_e;

  // Longest hold time reported to the timed port.
  localparam logic [15:0] HOLD_LIMIT_MS = 16'd60000;

  // One pass of an item down the row of slot cells.
  typedef struct packed {
    logic        valid;
    cmd_e        cmd;
    logic [15:0] lvl_lo;
    logic [15:0] lvl_hi;
    logic [15:0] dur;
    logic [15:0] elapsed;
    logic        placed;
    logic [15:0] max_lo;
    logic [15:0] max_hi;
    logic [15:0] max_left;
  } wave_t;

  // One finished result word.
  typedef struct packed {
    logic        send;
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic [15:0] hold_ms;
    logic        dropped;
  } result_t;

endpackage

`default_nettype wire

/* hdl/rumble_request_mixer.sv */
`default_nettype none

// Rumble request mixer. Play, tick and stop words arrive on the slave stream
// (command in tuser) and each produces exactly one result word on the master
// stream, carrying the mixed motor speeds and hold time in tdata and the send
// and dropped flags in tuser. The slot table is a row of SLOTS cells; an item
// travels down the row one cell per cycle, updating each slot and gathering
// the maxima as it goes. The result from the last cell goes to the output
// register, or to a pending word while the output is stalled, and a new item
// is taken once that result has reached the output register. A play takes
// the lowest free slot. The timed_port_present register resets to 1 and is
// written through cfg_we_i / cfg_wdata_i; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module rumble_request_mixer
  import rrm_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_wdata_i,     // timed_port_present
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,    // low_level, high_level, duration_ms, elapsed_ms
  input  wire  [1:0]  s_axis_tuser,    // cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,    // left_speed, right_speed, hold_ms
  output logic [1:0]  m_axis_tuser     // send, dropped
);

  logic        timed_q;
  logic        active_q, active_d;
  wave_t       launch_q, launch_d;
  logic [15:0] applied_lo_q, applied_lo_d;
  logic [15:0] applied_hi_q, applied_hi_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  logic        pend_valid_q, pend_valid_d;
  result_t     pend_q, pend_d;
  wave_t       chain [SLOTS+1];
  wave_t       exit_w;
  result_t     res;
  logic        accept;
  logic        out_free;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !active_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timed_q <= 1'b1;
    end else if (cfg_we_i) begin
      timed_q <= cfg_wdata_i;
    end
  end

  // Launch a new wave into the first cell.
  always_comb begin
    launch_d          = '0;
    launch_d.valid    = accept;
    launch_d.cmd      = cmd_e'(s_axis_tuser);
    launch_d.lvl_lo   = s_axis_tdata[15:0];
    launch_d.lvl_hi   = s_axis_tdata[31:16];
    launch_d.dur      = s_axis_tdata[47:32];
    launch_d.elapsed  = s_axis_tdata[63:48];
  end

  // Row of slot cells.
  assign chain[0] = launch_q;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rrm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wave_i (chain[g]),
      .wave_o (chain[g+1])
    );
  end

  assign exit_w = chain[SLOTS];

  // Build the result from the wave leaving the last cell.
  always_comb begin
    res.left_speed  = exit_w.max_lo;
    res.right_speed = exit_w.max_hi;
    res.send        = ((exit_w.cmd == CMD_PLAY) && exit_w.placed) ||
                      (exit_w.max_lo != applied_lo_q) ||
                      (exit_w.max_hi != applied_hi_q);
    res.dropped     = (exit_w.cmd == CMD_PLAY) && (exit_w.dur != 16'd0) &&
                      !exit_w.placed;
    if (!timed_q) begin
      res.hold_ms = 16'd0;
    end else if (exit_w.max_left > HOLD_LIMIT_MS) begin
      res.hold_ms = HOLD_LIMIT_MS;
    end else begin
      res.hold_ms = exit_w.max_left;
    end
  end

  // Output register with one pending word behind it.
  always_comb begin
    active_d     = active_q;
    applied_lo_d = applied_lo_q;
    applied_hi_d = applied_hi_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (exit_w.valid) begin
      if (res.send) begin
        applied_lo_d = exit_w.max_lo;
        applied_hi_d = exit_w.max_hi;
      end
      if (out_free) begin
        out_valid_d = 1'b1;
        out_d       = res;
        active_d    = 1'b0;
      end else begin
        pend_valid_d = 1'b1;
        pend_d       = res;
      end
    end else if (pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
      active_d     = 1'b0;
    end

    if (accept) begin
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      launch_q     <= '0;
      applied_lo_q <= 16'd0;
      applied_hi_q <= 16'd0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      active_q     <= active_d;
      launch_q     <= launch_d;
      applied_lo_q <= applied_lo_d;
      applied_hi_q <= applied_hi_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.hold_ms, out_q.right_speed, out_q.left_speed};
  assign m_axis_tuser  = {out_q.dropped, out_q.send};

endmodule

`default_nettype wire

/* hdl/rrm_cell.sv */
`default_nettype none

module rrm_cell
  import rrm_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wave_t wave_i,
  output wave_t wave_o
);

  logic        busy_q, busy_d;
  logic [15:0] low_q, low_d;
  logic [15:0] high_q, high_d;
  logic [15:0] left_q, left_d;
  wave_t       wave_q, wave_d;

  // Apply the passing command to this slot and fold it into the running maxima.
  always_comb begin
    busy_d = busy_q;
    low_d  = low_q;
    high_d = high_q;
    left_d = left_q;
    wave_d = wave_i;

    if (wave_i.valid) begin
      unique case (wave_i.cmd)
        CMD_PLAY: begin
          if ((wave_i.dur != 16'd0) && !wave_i.placed && !busy_q) begin
            busy_d        = 1'b1;
            low_d         = wave_i.lvl_lo;
            high_d        = wave_i.lvl_hi;
            left_d        = wave_i.dur;
            wave_d.placed = 1'b1;
          end
        end
        CMD_TICK: begin
          if (busy_q) begin
            if (left_q <= wave_i.elapsed) begin
              busy_d = 1'b0;
            end else begin
              left_d = left_q - wave_i.elapsed;
            end
          end
        end
        CMD_STOP: begin
          busy_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (busy_d) begin
      if (low_d > wave_i.max_lo) begin
        wave_d.max_lo = low_d;
      end
      if (high_d > wave_i.max_hi) begin
        wave_d.max_hi = high_d;
      end
      if (left_d > wave_i.max_left) begin
        wave_d.max_left = left_d;
      end
    end
  end

  // Slot occupancy and the outgoing wave valid are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      wave_q <= '0;
    end else begin
      busy_q <= busy_d;
      wave_q <= wave_d;
    end
  end

  // Slot contents are only read while the slot is busy.
  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
    left_q <= left_d;
  end

  assign wave_o = wave_q;

endmodule

`default_nettype wire

/* hdl/rrm_checker.sv */
`default_nettype none

module rrm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        cfg_we_i,
  input wire        cfg_wdata_i,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [63:0] s_axis_tdata,
  input wire [1:0]  s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);

  // The hold time never exceeds the clamp.
  a_hold_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:32] <= 16'd60000))
    else $error("hold_ms above limit");

  // A dropped play leaves the mix unchanged, so nothing is sent.
  a_drop_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
    else $error("dropped word also requests a send");

  // Only one item is in flight: ready drops after an accepted word.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted while one is in flight");

  // A stalled result word holds its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind rumble_request_mixer rrm_checker u_rrm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* test/rumble_request_mixer_tb.sv */
`timescale 1ns / 100ps

module rumble_request_mixer_tb;
  import rrm_pkg::*;

  localparam int SLOTS = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One input word as the sender sees it.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] lvl_lo;
    logic [15:0] lvl_hi;
    logic [15:0] dur;
    logic [15:0] elapsed;
  } rumble_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // low_level, high_level, duration_ms, elapsed_ms
  logic [1:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // left_speed, right_speed, hold_ms
  logic [1:0]  m_axis_tuser;        // send, dropped

  rumble_request_mixer #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Words waiting to be sent and mixes waiting to come out.
  rumble_word_t word_queue[$];
  result_t      expected_mix[$];

  // Shadow copy of the slot table and the last speeds sent.
  logic        slot_taken[SLOTS];
  logic [15:0] slot_lo[SLOTS];
  logic [15:0] slot_hi[SLOTS];
  logic [15:0] slot_ms[SLOTS];
  logic [15:0] sent_lo = '0;
  logic [15:0] sent_hi = '0;
  logic        timed_port_en = 1'b1;

  int  mismatches = 0;
  int  results_checked = 0;
  int  plays_placed = 0;
  int  plays_dropped = 0;
  int  ticks_seen = 0;
  int  stops_seen = 0;
  int  resends_seen = 0;
  bit  word_taken = 1'b0;
  bit  quiet_tail = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_taken[i] = 1'b0;
    end
  end

  // Applies one accepted word to the shadow table and returns the mix it yields.
  function automatic result_t mix_predict(rumble_word_t w);
    result_t     res;
    logic        force_send;
    int          pick;
    logic [15:0] top_lo, top_hi, top_ms;

    force_send = 1'b0;
    pick = -1;
    top_lo = '0;
    top_hi = '0;
    top_ms = '0;
    res = '0;
    if (w.cmd == CMD_PLAY && w.dur != 0) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_taken[i]) pick = i;
      end
      if (pick >= 0) begin
        slot_taken[pick] = 1'b1;
        slot_lo[pick] = w.lvl_lo;
        slot_hi[pick] = w.lvl_hi;
        slot_ms[pick] = w.dur;
        force_send = 1'b1;
        plays_placed++;
      end else begin
        res.dropped = 1'b1;
        plays_dropped++;
      end
    end else if (w.cmd == CMD_TICK) begin
      ticks_seen++;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_taken[i]) begin
          if (slot_ms[i] <= w.elapsed) slot_taken[i] = 1'b0;
          else slot_ms[i] = slot_ms[i] - w.elapsed;
        end
      end
    end else if (w.cmd == CMD_STOP) begin
      stops_seen++;
      for (int i = 0; i < SLOTS; i++) begin
        slot_taken[i] = 1'b0;
      end
    end

    for (int i = 0; i < SLOTS; i++) begin
      if (slot_taken[i]) begin
        if (slot_lo[i] > top_lo) top_lo = slot_lo[i];
        if (slot_hi[i] > top_hi) top_hi = slot_hi[i];
        if (slot_ms[i] > top_ms) top_ms = slot_ms[i];
      end
    end

    res.send = force_send || top_lo != sent_lo || top_hi != sent_hi;
    if (res.send) begin
      sent_lo = top_lo;
      sent_hi = top_hi;
      resends_seen++;
    end
    res.left_speed = top_lo;
    res.right_speed = top_hi;
    res.hold_ms = (top_ms > HOLD_LIMIT_MS) ? HOLD_LIMIT_MS : top_ms;
    if (!timed_port_en) res.hold_ms = '0;
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checking first, then prediction for the word taken at this edge.
  always @(posedge clk_i) begin
    result_t      want;
    rumble_word_t w;

    word_taken = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_mix.size() == 0) begin
          $display("%0t: result with nothing expected, got send %0b left %0d",
                   $time, m_axis_tuser[0], m_axis_tdata[15:0]);
          $display("  right %0d hold %0d dropped %0b",
                   m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser[1]);
          mismatches++;
        end else begin
          want = expected_mix.pop_front();
          check_field("send", 16'(want.send), 16'(m_axis_tuser[0]));
          check_field("left_speed", want.left_speed, m_axis_tdata[15:0]);
          check_field("right_speed", want.right_speed, m_axis_tdata[31:16]);
          check_field("hold_ms", want.hold_ms, m_axis_tdata[47:32]);
          check_field("dropped", 16'(want.dropped), 16'(m_axis_tuser[1]));
        end
        results_checked++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        word_taken = 1'b1;
        w.cmd = s_axis_tuser;
        w.lvl_lo = s_axis_tdata[15:0];
        w.lvl_hi = s_axis_tdata[31:16];
        w.dur = s_axis_tdata[47:32];
        w.elapsed = s_axis_tdata[63:48];
        expected_mix = {expected_mix, mix_predict(w)};
        void'(word_queue.pop_front());
      end
    end
  end

  // Sender: holds a word until it is taken, with random gaps and calm stretches.
  int send_gap = 0;
  int send_calm = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !word_taken)) begin
      if (send_gap == 0 && send_calm == 0 && !quiet_tail) begin
        if ($urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
        else if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(20, 80);
      end
      if (send_calm > 0) send_calm--;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (word_queue.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= word_queue[0].cmd;
        s_axis_tdata <= {word_queue[0].elapsed, word_queue[0].dur,
                         word_queue[0].lvl_hi, word_queue[0].lvl_lo};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  int  recv_gap = 0;
  int  recv_calm = 0;
  int  long_stall_left = 0;
  bit  long_stall_done = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!long_stall_done && results_checked >= 150) begin
        long_stall_done = 1'b1;
        long_stall_left = 250;
      end
      if (long_stall_left > 0) begin
        long_stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (recv_gap == 0 && recv_calm == 0 && !quiet_tail) begin
          if ($urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 9);
          else if ($urandom_range(0, 24) == 0) recv_calm = $urandom_range(20, 80);
        end
        if (recv_calm > 0) recv_calm--;
        if (recv_gap > 0) begin
          recv_gap--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  function automatic void add_word(logic [1:0] cmd, logic [15:0] lvl_lo, logic [15:0] lvl_hi,
                                   logic [15:0] dur, logic [15:0] elapsed);
    rumble_word_t w;
    w.cmd = cmd;
    w.lvl_lo = lvl_lo;
    w.lvl_hi = lvl_hi;
    w.dur = dur;
    w.elapsed = elapsed;
    word_queue = {word_queue, w};
  endfunction

  function automatic logic [15:0] rand_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly plays and short ticks so the table fills and drains; some noise.
  function automatic void add_random_word();
    int          r;
    logic [15:0] dur, elapsed;

    r = $urandom_range(0, 99);
    dur = 16'($urandom_range(0, 65535));
    elapsed = 16'($urandom_range(0, 65535));
    if (r < 47) begin
      case ($urandom_range(0, 9))
        0, 1: dur = 16'($urandom_range(1, 65535));
        2: dur = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd60001;
        default: dur = 16'($urandom_range(1, 400));
      endcase
      add_word(CMD_PLAY, rand_level(), rand_level(), dur, elapsed);
    end else if (r < 52) begin
      add_word(CMD_PLAY, rand_level(), rand_level(), 16'd0, elapsed);
    end else if (r < 87) begin
      case ($urandom_range(0, 9))
        0: elapsed = 16'd0;
        1: elapsed = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        default: elapsed = 16'($urandom_range(1, 120));
      endcase
      add_word(CMD_TICK, rand_level(), rand_level(), dur, elapsed);
    end else if (r < 94) begin
      add_word(CMD_STOP, rand_level(), rand_level(), dur, elapsed);
    end else begin
      add_word(CMD_UNUSED, rand_level(), rand_level(), dur, elapsed);
    end
  endfunction

  // Waits until every word is sent and every mix is back, then lets the block settle.
  task automatic drain();
    while (word_queue.size() != 0 || expected_mix.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SLOTS + 4) @(posedge clk_i);
  endtask

  task automatic write_timed_port(logic value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    timed_port_en = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      add_random_word();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: extremes, each command, a full table and the hold clamp.
    add_word(CMD_PLAY, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    add_word(CMD_PLAY, 16'h0000, 16'hFFFF, 16'd1, 16'hFFFF);
    add_word(CMD_PLAY, 16'h1234, 16'h4321, 16'd0, 16'h0000);
    add_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'd0);
    add_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    for (int i = 1; i < SLOTS; i++) begin
      add_word(CMD_PLAY, 16'(i * 1000), 16'(65535 - i * 3000), 16'(i * 100), 16'h0000);
    end
    // The table is full now, so this play is lost.
    add_word(CMD_PLAY, 16'hFFFF, 16'hFFFF, 16'd500, 16'h0000);
    add_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'd60000);
    add_word(CMD_PLAY, 16'h0001, 16'h8000, 16'd60001, 16'h0000);
    add_word(CMD_PLAY, 16'h8000, 16'h0001, 16'd60000, 16'h0000);
    add_word(CMD_STOP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_word(CMD_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    add_word(CMD_PLAY, 16'h00FF, 16'hFF00, 16'd2, 16'h0000);
    add_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    drain();

    // Random phases with the timed port switched off and on.
    write_timed_port(1'b0);
    run_random(320);
    write_timed_port(1'b1);
    run_random(320);
    write_timed_port(1'b0);
    run_random(300);
    write_timed_port(1'b1);
    quiet_tail = 1'b1;
    run_random(300);

    $display("Checked %0d mixes: %0d plays placed, %0d dropped on a full table, %0d ticks,",
             results_checked, plays_placed, plays_dropped, ticks_seen);
    $display("%0d stops and %0d resends, with the timed port both off and on.",
             stops_seen, resends_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d mixes still expected", expected_mix.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
